### rtl/core/gdad_pkg.sv
// Shared types, constants and calendar functions for the date adder.
package gdad_pkg;

   localparam int DayW   = 5;
   localparam int MonthW = 4;
   localparam int YearW  = 16;
   localparam int OffW   = 16;
   localparam int StatW  = 2;
   localparam int StepW  = 3;
   localparam int ModW   = 9;   // year mod 400 fits in 9 bits
   localparam int KW     = 3;   // shift index of the mod-400 reduction

   localparam int ReqDataW = 48;
   localparam int RspDataW = 32;

   localparam logic [YearW:0]  MinYear  = 17'd1582;
   localparam logic [YearW:0]  Yr400    = 17'd400;
   localparam logic [KW-1:0]   KStart   = 3'd7;
   localparam logic [ModW-1:0] ModLast  = 9'd399;
   localparam logic [MonthW-1:0] MonJan = 4'd1;
   localparam logic [MonthW-1:0] MonFeb = 4'd2;
   localparam logic [MonthW-1:0] MonDec = 4'd12;

   localparam logic [StatW-1:0] StOk      = 2'd0;
   localparam logic [StatW-1:0] StInvalid = 2'd1;
   localparam logic [StatW-1:0] StRange   = 2'd2;

   typedef logic [StepW-1:0] step_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_MOD,
      OP_CHECK,
      OP_ADD,
      OP_FWD,
      OP_BWD,
      OP_FIN
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_K_NZ,
      C_INVALID,
      C_D_GT_LEN,
      C_D_LT_1,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic no_req;
      logic k_nz;
      logic invalid;
      logic d_gt_len;
      logic d_lt_1;
      logic out_busy;
   } flags_type;

   // Leap test on year mod 400: divisible by 4, and not a century unless zero.
   function automatic logic is_leap(input logic [ModW-1:0] r);
      logic century;
      century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
      return (r[1:0] == 2'b00) && !century;
   endfunction

   function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
      logic [DayW-1:0] len;
      case (m)
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         MonFeb:                  len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

### rtl/core/gdad_seq.sv
// Microcode store and step counter of the date adder.
module gdad_seq (
   input  logic               clock,
   input  logic               reset,
   input  gdad_pkg::flags_type flags,
   output gdad_pkg::ctrl_type  ctrl
);
   import gdad_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     take;

   // Program: load, reduce year mod 400, check, add, walk months, deliver.
   always_comb begin
      unique case (step_ff)
         3'd0:    ctrl = '{op: OP_LOAD,  cond: C_NO_REQ,   target: 3'd0};
         3'd1:    ctrl = '{op: OP_MOD,   cond: C_K_NZ,     target: 3'd1};
         3'd2:    ctrl = '{op: OP_CHECK, cond: C_INVALID,  target: 3'd6};
         3'd3:    ctrl = '{op: OP_ADD,   cond: C_NEVER,    target: 3'd0};
         3'd4:    ctrl = '{op: OP_FWD,   cond: C_D_GT_LEN, target: 3'd4};
         3'd5:    ctrl = '{op: OP_BWD,   cond: C_D_LT_1,   target: 3'd5};
         3'd6:    ctrl = '{op: OP_FIN,   cond: C_OUT_BUSY, target: 3'd6};
         3'd7:    ctrl = '{op: OP_NOP,   cond: C_ALWAYS,   target: 3'd0};
         default: ctrl = '{op: OP_NOP,   cond: C_ALWAYS,   target: 3'd0};
      endcase
   end

   always_comb begin
      unique case (ctrl.cond)
         C_NEVER:    take = 1'b0;
         C_ALWAYS:   take = 1'b1;
         C_NO_REQ:   take = flags.no_req;
         C_K_NZ:     take = flags.k_nz;
         C_INVALID:  take = flags.invalid;
         C_D_GT_LEN: take = flags.d_gt_len;
         C_D_LT_1:   take = flags.d_lt_1;
         C_OUT_BUSY: take = flags.out_busy;
         default:    take = 1'b0;
      endcase
   end

   always_comb begin
      step_in = take ? ctrl.target : step_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### rtl/core/gdad_dp.sv
// Datapath of the date adder: date registers, mod-400 tracker, output register.
module gdad_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  gdad_pkg::ctrl_type             ctrl,
   output gdad_pkg::flags_type            flags,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [gdad_pkg::ReqDataW-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [gdad_pkg::RspDataW-1:0]  rsp_tdata,
   output logic [gdad_pkg::StatW-1:0]     rsp_tuser
);
   import gdad_pkg::*;

   logic signed [YearW:0] d_ff,  d_in;
   logic [MonthW-1:0]     m_ff,  m_in;
   logic [YearW:0]        y_ff,  y_in;
   logic [YearW-1:0]      r_ff,  r_in;
   logic [OffW-1:0]       off_ff, off_in;
   logic [KW-1:0]         k_ff,  k_in;
   logic [StatW-1:0]      st_ff, st_in;

   logic                  out_valid_ff, out_valid_in;
   logic [DayW-1:0]       out_day_ff,   out_day_in;
   logic [MonthW-1:0]     out_mon_ff,   out_mon_in;
   logic [YearW-1:0]      out_year_ff,  out_year_in;
   logic [StatW-1:0]      out_st_ff,    out_st_in;

   logic [ModW-1:0]       r9;
   logic [YearW:0]        mod_sub;
   logic [DayW-1:0]       len_cur;
   logic [MonthW-1:0]     m_inc, m_dec;
   logic [YearW:0]        y_inc, y_dec;
   logic [ModW-1:0]       r_inc, r_dec;
   logic [DayW-1:0]       len_dec;
   logic                  bad_date;
   logic                  out_busy;
   logic                  out_load;

   assign r9      = r_ff[ModW-1:0];
   assign mod_sub = Yr400 << k_ff;
   assign len_cur = month_len(m_ff, is_leap(r9));

   // Next and previous month with the year and its mod-400 count wrapping.
   always_comb begin
      if (m_ff == MonDec) begin
         m_inc = MonJan;
         y_inc = y_ff + 17'd1;
         r_inc = (r9 == ModLast) ? '0 : r9 + 9'd1;
      end else begin
         m_inc = m_ff + 4'd1;
         y_inc = y_ff;
         r_inc = r9;
      end
      if (m_ff == MonJan) begin
         m_dec = MonDec;
         y_dec = y_ff - 17'd1;
         r_dec = (r9 == '0) ? ModLast : r9 - 9'd1;
      end else begin
         m_dec = m_ff - 4'd1;
         y_dec = y_ff;
         r_dec = r9;
      end
      len_dec = month_len(m_dec, is_leap(r_dec));
   end

   assign bad_date = (y_ff < MinYear) || (m_ff == '0) || (m_ff > MonDec) ||
                     (d_ff == '0) || (d_ff > $signed({12'd0, len_cur}));

   assign out_busy = out_valid_ff && !rsp_tready;
   assign out_load = (ctrl.op == OP_FIN) && !out_busy;

   always_comb begin
      flags.no_req   = !req_tvalid;
      flags.k_nz     = (k_ff != '0);
      flags.invalid  = bad_date;
      flags.d_gt_len = d_ff > $signed({12'd0, len_cur});
      flags.d_lt_1   = d_ff < $signed(17'sd1);
      flags.out_busy = out_busy;
   end

   assign req_tready = (ctrl.op == OP_LOAD);

   always_comb begin
      d_in   = d_ff;
      m_in   = m_ff;
      y_in   = y_ff;
      r_in   = r_ff;
      off_in = off_ff;
      k_in   = k_ff;
      st_in  = st_ff;
      unique case (ctrl.op)
         OP_LOAD: begin
            if (req_tvalid) begin
               d_in   = $signed({12'd0, req_tdata[4:0]});
               m_in   = req_tdata[8:5];
               y_in   = {1'b0, req_tdata[24:9]};
               r_in   = req_tdata[24:9];
               off_in = req_tdata[40:25];
               k_in   = KStart;
            end
         end
         OP_MOD: begin
            // One restoring step of year mod 400 per cycle.
            if ({1'b0, r_ff} >= mod_sub) begin
               r_in = r_ff - mod_sub[YearW-1:0];
            end
            k_in = k_ff - 3'd1;
         end
         OP_CHECK: begin
            st_in = bad_date ? StInvalid : StOk;
         end
         OP_ADD: begin
            d_in = d_ff + $signed({off_ff[OffW-1], off_ff});
         end
         OP_FWD: begin
            if (flags.d_gt_len) begin
               d_in = d_ff - $signed({12'd0, len_cur});
               m_in = m_inc;
               y_in = y_inc;
               r_in = {7'd0, r_inc};
            end
         end
         OP_BWD: begin
            if (flags.d_lt_1) begin
               d_in = d_ff + $signed({12'd0, len_dec});
               m_in = m_dec;
               y_in = y_dec;
               r_in = {7'd0, r_dec};
            end
         end
         OP_FIN, OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_day_in  = out_day_ff;
      out_mon_in  = out_mon_ff;
      out_year_in = out_year_ff;
      out_st_in   = out_st_ff;
      if (out_load) begin
         if (st_ff == StInvalid) begin
            out_day_in  = '0;
            out_mon_in  = '0;
            out_year_in = '0;
            out_st_in   = StInvalid;
         end else begin
            out_day_in  = d_ff[DayW-1:0];
            out_mon_in  = m_ff;
            // Saturate a year past the top of the field.
            out_year_in = y_ff[YearW] ? '1 : y_ff[YearW-1:0];
            out_st_in   = y_ff[YearW] ? StRange : StOk;
         end
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      m_ff        <= m_in;
      y_ff        <= y_in;
      r_ff        <= r_in;
      off_ff      <= off_in;
      k_ff        <= k_in;
      st_ff       <= st_in;
      out_day_ff  <= out_day_in;
      out_mon_ff  <= out_mon_in;
      out_year_ff <= out_year_in;
      out_st_ff   <= out_st_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_year_ff, out_mon_ff, out_day_ff};
   assign rsp_tuser  = out_st_ff;

endmodule

### rtl/core/gregorian_date_add_days.sv
// Top level of the Gregorian date adder: sequencer plus datapath.
//
//   channel  dir  tdata fields (low bit up)                      tuser
//   req_     in   day_in 5, month_in 4, year_in 16,
//                 days_to_add 16, zero pad 7                     -
//   rsp_     out  day_out 5, month_out 4, year_out 16, pad 7     status 2
//
// One item at a time. Its steps in order: load, year mod 400 reduction, check,
// add, the forward and backward month walks (one month a cycle, up to about
// 1080 months for the widest offset, each walk with an exit step), delivery and
// a return step. An invalid date skips the add and the walks. The result waits
// in an output register; the sequencer stalls at delivery only while that
// register is full and not taken. Reset (synchronous) returns the step counter
// to the load step and empties the output register.
module gregorian_date_add_days (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // day_in[4:0], month_in[8:5], year_in[24:9], days_to_add[40:25], zeros
   input  logic [gdad_pkg::ReqDataW-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // day_out[4:0], month_out[8:5], year_out[24:9], zeros
   output logic [gdad_pkg::RspDataW-1:0]  rsp_tdata,
   // status[1:0]
   output logic [gdad_pkg::StatW-1:0]     rsp_tuser
);
   import gdad_pkg::*;

   ctrl_type  ctrl;
   flags_type flags;

   gdad_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   gdad_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .flags      (flags),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the Gregorian date adder, with random stalls on both sides.
module testbench;

   localparam int DayW     = gdad_pkg::DayW;
   localparam int MonthW   = gdad_pkg::MonthW;
   localparam int YearW    = gdad_pkg::YearW;
   localparam int OffW     = gdad_pkg::OffW;
   localparam int StatW    = gdad_pkg::StatW;
   localparam int ReqW     = gdad_pkg::ReqDataW;
   localparam int RspW     = gdad_pkg::RspDataW;
   localparam int FirstYear = int'(gdad_pkg::MinYear);
   localparam int YearTop  = 2**YearW - 1;

   localparam int IdlePct       = 31;
   localparam int LongHold      = 300;
   localparam int DrainCycles   = 60;
   localparam int NoAcceptLimit = 40000;
   localparam int RandomItems   = 520;
   localparam int SteadyItems   = 120;

   typedef struct {
      logic [DayW-1:0]          day;
      logic [MonthW-1:0]        month;
      logic [YearW-1:0]         year;
      logic signed [OffW-1:0]   offset;
   } date_req_type;

   typedef struct {
      logic [DayW-1:0]   day;
      logic [MonthW-1:0] month;
      logic [YearW-1:0]  year;
      logic [StatW-1:0]  status;
   } date_rsp_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [ReqW-1:0]  req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RspW-1:0]  rsp_tdata;
   logic [StatW-1:0] rsp_tuser;

   logic             long_hold_go = 1'b0;
   bit               gaps_on = 1'b1;

   date_rsp_type expected_dates[$];
   int        mismatch_count = 0;
   int        dates_sent     = 0;
   int        results_seen   = 0;
   int        invalid_seen   = 0;
   int        overflow_seen  = 0;
   int        hold_left      = 0;
   int        stuck_cycles   = 0;

   gregorian_date_add_days i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit leap_year(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int days_in_month(input int m, input int y);
      case (m)
         4, 6, 9, 11: return 30;
         2:           return leap_year(y) ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   // Walk the offset month by month, the way the hardware does.
   function automatic date_rsp_type add_days_to_date(input date_req_type r);
      date_rsp_type res;
      int d, m, y;
      d = int'(r.day);
      m = int'(r.month);
      y = int'(r.year);
      res.status = gdad_pkg::StOk;
      if (y < FirstYear || m < 1 || m > 12 || d < 1 || d > days_in_month(m, y)) begin
         res.day    = '0;
         res.month  = '0;
         res.year   = '0;
         res.status = gdad_pkg::StInvalid;
         return res;
      end
      d += int'(r.offset);
      while (d > days_in_month(m, y)) begin
         d -= days_in_month(m, y);
         m++;
         if (m > 12) begin
            m = 1;
            y++;
         end
      end
      while (d < 1) begin
         m--;
         if (m < 1) begin
            m = 12;
            y--;
         end
         d += days_in_month(m, y);
      end
      // Saturate the year instead of wrapping.
      if (y > YearTop) begin
         y = YearTop;
         res.status = gdad_pkg::StRange;
      end else if (y < 0) begin
         y = 0;
         res.status = gdad_pkg::StRange;
      end
      res.day   = DayW'(d);
      res.month = MonthW'(m);
      res.year  = YearW'(y);
      return res;
   endfunction

   function automatic date_req_type make_date(input int d, input int m, input int y,
                                              input int off);
      date_req_type r;
      r.day    = DayW'(d);
      r.month  = MonthW'(m);
      r.year   = YearW'(y);
      r.offset = OffW'(off);
      return r;
   endfunction

   // Mostly short offsets keep the month walk short; a few span the full range.
   function automatic int random_offset();
      int pick;
      pick = $urandom_range(99);
      if (pick < 75)
         return int'($urandom_range(2000)) - 1000;
      else if (pick < 90)
         return int'($urandom_range(16000)) - 8000;
      else
         return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic date_req_type random_date();
      int pick, y, m, d;
      pick = $urandom_range(99);
      if (pick < 20)
         return make_date($urandom_range(31), $urandom_range(15), $urandom_range(YearTop),
                          random_offset());
      if (pick < 30)
         y = $urandom_range(YearTop, FirstYear);
      else if (pick < 36)
         y = $urandom_range(YearTop, YearTop - 200);
      else
         y = $urandom_range(2600, FirstYear);
      m = $urandom_range(12, 1);
      if ($urandom_range(99) < 20)
         d = days_in_month(m, y);
      else
         d = $urandom_range(days_in_month(m, y), 1);
      return make_date(d, m, y, random_offset());
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns  MISMATCH  %s", $time, msg);
      mismatch_count++;
   endtask

   // Offer one date and wait for the transaction; valid stays high into the next item.
   task automatic offer_date(input date_req_type r);
      if (gaps_on && $urandom_range(99) < IdlePct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= ReqW'({$urandom, $urandom});
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ReqW'({r.offset, r.year, r.month, r.day});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_dates.push_back(add_days_to_date(r));
      dates_sent++;
   endtask

   // Receiver: random stalls, a long hold on request, and the result check.
   always @(posedge clock) begin : rsp_side
      date_rsp_type want;
      logic [DayW-1:0]   got_day;
      logic [MonthW-1:0] got_month;
      logic [YearW-1:0]  got_year;
      got_day   = rsp_tdata[DayW-1:0];
      got_month = rsp_tdata[DayW +: MonthW];
      got_year  = rsp_tdata[DayW+MonthW +: YearW];
      if (rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_dates.size() == 0) begin
            report_mismatch($sformatf("result %0d with no pending transaction", results_seen));
         end else begin
            want = expected_dates.pop_front();
            if (want.status == gdad_pkg::StInvalid) invalid_seen++;
            if (want.status == gdad_pkg::StRange) overflow_seen++;
            if (rsp_tuser !== want.status)
               report_mismatch($sformatf("result %0d status: got %0d, expected %0d",
                                         results_seen, rsp_tuser, want.status));
            if (got_day !== want.day)
               report_mismatch($sformatf("result %0d day: got %0d, expected %0d",
                                         results_seen, got_day, want.day));
            if (got_month !== want.month)
               report_mismatch($sformatf("result %0d month: got %0d, expected %0d",
                                         results_seen, got_month, want.month));
            if (got_year !== want.year)
               report_mismatch($sformatf("result %0d year: got %0d, expected %0d",
                                         results_seen, got_year, want.year));
         end
      end
      if (long_hold_go)
         hold_left = LongHold;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(99) < IdlePct) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= NoAcceptLimit) begin
         $display("Timeout: no transaction for %0d cycles", NoAcceptLimit);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_invalid_dates();
      offer_date(make_date(1, 1, FirstYear - 1, 0));
      offer_date(make_date(15, 6, 0, 5));
      offer_date(make_date(1, 0, 2000, 1));
      offer_date(make_date(1, 13, 2000, 1));
      offer_date(make_date(31, 15, YearTop, -1));
      offer_date(make_date(0, 3, 2020, 1));
      offer_date(make_date(31, 4, 2021, 0));
      offer_date(make_date(29, 2, 1900, 0));
      offer_date(make_date(30, 2, 2000, 0));
   endtask

   task automatic test_leap_rules();
      offer_date(make_date(29, 2, 2000, 0));
      offer_date(make_date(28, 2, 2000, 1));
      offer_date(make_date(28, 2, 2100, 1));
      offer_date(make_date(29, 2, 2004, 365));
      offer_date(make_date(1, 1, FirstYear, -1));
   endtask

   task automatic test_offset_extremes();
      offer_date(make_date(15, 7, 2000, 32767));
      offer_date(make_date(15, 7, 2000, -32768));
      offer_date(make_date(31, 12, 1999, 1));
      offer_date(make_date(1, 3, 2400, -1));
      offer_date(make_date(31, 1, 2023, 0));
   endtask

   task automatic test_year_overflow();
      offer_date(make_date(31, 12, YearTop, 1));
      offer_date(make_date(1, 1, YearTop - 35, 32767));
      offer_date(make_date(31, 12, YearTop, -32768));
      offer_date(make_date(1, 1, YearTop, 0));
   endtask

   // Hold the result side long enough for the block to fill and stall its input.
   task automatic test_output_backpressure();
      long_hold_go <= 1'b1;
      @(posedge clock);
      long_hold_go <= 1'b0;
      repeat (10) offer_date(make_date($urandom_range(28, 1), $urandom_range(12, 1),
                                       $urandom_range(2600, FirstYear),
                                       int'($urandom_range(400)) - 200));
   endtask

   task automatic test_random_dates();
      gaps_on = 1'b0;
      repeat (SteadyItems) offer_date(random_date());
      gaps_on = 1'b1;
      repeat (RandomItems - SteadyItems) offer_date(random_date());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_invalid_dates();
      test_leap_rules();
      test_offset_extremes();
      test_year_overflow();
      test_output_backpressure();
      test_random_dates();
      req_tvalid <= 1'b0;
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("Covered %0d dates: invalid inputs, leap rules, full offset range, year overflow,",
               dates_sent);
      $display("stalls on both sides; %0d results (%0d invalid, %0d overflow)",
               results_seen, invalid_seen, overflow_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/gdad_pkg.sv
rtl/core/gdad_seq.sv
rtl/core/gdad_dp.sv
rtl/core/gregorian_date_add_days.sv
dv/testbench.sv
